@@ hdl/pcbd_pkg.sv @@
// prefix code bit decoder: shared types, constants and command codes
// no dependencies; imported by every module of the block
package pcbd_pkg;

	localparam int NUM_SYMBOLS  = 256;
	localparam int MAX_CODE_LEN = 16;

	localparam int CMD_W  = 2;
	localparam int SYMP_W = 8;
	localparam int CODE_W = 16;
	localparam int LEN_W  = 5;

	localparam int SYM_W = $clog2(NUM_SYMBOLS);
	localparam int ACC_W = MAX_CODE_LEN;
	localparam int CMP_W = (ACC_W > CODE_W) ? ACC_W : CODE_W;
	localparam int CNT_W = $clog2(NUM_SYMBOLS + 1);
	localparam int NUM_LENS = MAX_CODE_LEN + 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_LOAD   = 2'd1,
		CMD_DECODE = 2'd2
	} cmd_t;

	localparam logic KIND_SYMBOL   = 1'b0;
	localparam logic KIND_OVERFLOW = 1'b1;

	typedef struct packed {
		logic              clear;
		logic              load;
		logic [SYM_W-1:0]  sym;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} tbl_wr_t;

endpackage

@@ hdl/prefix_code_bit_decoder.sv @@
// prefix code bit decoder top: input register, accumulator, result register
// depends on pcbd_pkg, pcbd_table, pcbd_prio
//
//  channel   handshake           fields
//  input     start / busy        cmd, entry_symbol, entry_code, entry_length, data_bit
//  result    done (strobe)       result_kind, decoded_symbol
//
// one word per cycle; busy stays low, a word is taken at every edge with start high
// a decode word's result, if any, raises done at the edge after the accepting edge
// table writes take effect before the next word is examined: no hazard between words
// the per-word path is the parallel compare over all table entries plus the priority tree
// arst_n empties the table and the accumulator; no clearing pass is needed
// done lasts one cycle and cannot be held off by the receiver
module prefix_code_bit_decoder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [pcbd_pkg::CMD_W-1:0]   cmd,
	input  logic [pcbd_pkg::SYMP_W-1:0]  entry_symbol,
	input  logic [pcbd_pkg::CODE_W-1:0]  entry_code,
	input  logic [pcbd_pkg::LEN_W-1:0]   entry_length,
	input  logic                         data_bit,
	output logic                         done,
	output logic                         result_kind,
	output logic [pcbd_pkg::SYMP_W-1:0]  decoded_symbol
);
	import pcbd_pkg::*;

	logic              vld_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic [SYMP_W-1:0] sym_s1;
	logic [CODE_W-1:0] code_s1;
	logic [LEN_W-1:0]  len_s1;
	logic              bit_s1;

	logic [ACC_W-1:0]  acc_bits_q;
	logic [LEN_W-1:0]  acc_len_q;
	logic              done_q;
	logic              kind_q;
	logic [SYMP_W-1:0] sym_q;

	tbl_wr_t                 wr;
	logic [ACC_W-1:0]        acc_bits_nx;
	logic [LEN_W-1:0]        acc_len_nx;
	logic [NUM_SYMBOLS-1:0]  match;
	logic [LEN_W-1:0]        longest;
	logic                    hit;
	logic [SYM_W-1:0]        hit_idx;
	logic                    is_clear;
	logic                    is_load;
	logic                    is_decode;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1  <= cmd;
			sym_s1  <= entry_symbol;
			code_s1 <= entry_code;
			len_s1  <= entry_length;
			bit_s1  <= data_bit;
		end
	end

	always_comb begin
		is_clear  = 1'b0;
		is_load   = 1'b0;
		is_decode = 1'b0;
		unique case (cmd_s1)
			CMD_CLEAR:  is_clear  = vld_s1;
			CMD_LOAD:   is_load   = vld_s1;
			CMD_DECODE: is_decode = vld_s1;
			default: ;
		endcase
	end

	always_comb begin
		wr.clear = is_clear;
		wr.load  = is_load && (32'(sym_s1) < NUM_SYMBOLS);
		wr.sym   = sym_s1[SYM_W-1:0];
		wr.code  = code_s1;
		wr.len   = len_s1;
	end

	if (ACC_W > 1) begin : g_shift
		assign acc_bits_nx = {acc_bits_q[ACC_W-2:0], bit_s1};
	end else begin : g_single
		assign acc_bits_nx = bit_s1;
	end
	assign acc_len_nx = acc_len_q + LEN_W'(1);

	pcbd_table u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr          (wr),
		.acc_bits_nx (CMP_W'(acc_bits_nx)),
		.acc_len_nx  (acc_len_nx),
		.match       (match),
		.longest     (longest)
	);

	pcbd_prio u_prio (
		.match (match),
		.hit   (hit),
		.idx   (hit_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_bits_q <= '0;
			acc_len_q  <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= is_decode && (hit || (acc_len_nx >= longest));
			if (is_clear) begin
				acc_bits_q <= '0;
				acc_len_q  <= '0;
			end else if (is_decode) begin
				if (hit || (acc_len_nx >= longest)) begin
					acc_bits_q <= '0;
					acc_len_q  <= '0;
				end else begin
					acc_bits_q <= acc_bits_nx;
					acc_len_q  <= acc_len_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_decode) begin
			kind_q <= hit ? KIND_SYMBOL : KIND_OVERFLOW;
			sym_q  <= hit ? SYMP_W'(hit_idx) : '0;
		end
	end

	assign done           = done_q;
	assign result_kind    = kind_q;
	assign decoded_symbol = sym_q;

endmodule

@@ hdl/pcbd_table.sv @@
// code table: per-symbol entries, per-length occupancy counts, parallel match
// depends on pcbd_pkg
module pcbd_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pcbd_pkg::tbl_wr_t                 wr,
	input  logic [pcbd_pkg::CMP_W-1:0]        acc_bits_nx,
	input  logic [pcbd_pkg::LEN_W-1:0]        acc_len_nx,
	output logic [pcbd_pkg::NUM_SYMBOLS-1:0]  match,
	output logic [pcbd_pkg::LEN_W-1:0]        longest
);
	import pcbd_pkg::*;

	logic              valid_q [NUM_SYMBOLS];
	logic [CODE_W-1:0] bits_q  [NUM_SYMBOLS];
	logic [LEN_W-1:0]  len_q   [NUM_SYMBOLS];
	logic [CNT_W-1:0]  cnt_q   [NUM_LENS];

	logic              new_valid;
	logic [CODE_W-1:0] new_bits;
	logic              old_valid;
	logic [LEN_W-1:0]  old_len;

	assign new_valid = (wr.len != '0) && (32'(wr.len) <= MAX_CODE_LEN);
	assign old_valid = valid_q[wr.sym];
	assign old_len   = len_q[wr.sym];

	// keep only the low len bits of the code
	always_comb begin
		for (int b = 0; b < CODE_W; b++) begin
			new_bits[b] = wr.code[b] && (b < 32'(wr.len));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SYMBOLS; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else if (wr.clear) begin
			for (int i = 0; i < NUM_SYMBOLS; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else if (wr.load) begin
			valid_q[wr.sym] <= new_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.load) begin
			bits_q[wr.sym] <= new_bits;
			len_q[wr.sym]  <= wr.len;
		end
	end

	// number of valid entries of each length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < NUM_LENS; l++) begin
				cnt_q[l] <= '0;
			end
		end else if (wr.clear) begin
			for (int l = 0; l < NUM_LENS; l++) begin
				cnt_q[l] <= '0;
			end
		end else if (wr.load) begin
			for (int l = 1; l < NUM_LENS; l++) begin
				cnt_q[l] <= cnt_q[l]
					+ CNT_W'(new_valid && (32'(wr.len) == l))
					- CNT_W'(old_valid && (32'(old_len) == l));
			end
		end
	end

	always_comb begin
		longest = '0;
		for (int l = 1; l < NUM_LENS; l++) begin
			if (cnt_q[l] != '0) begin
				longest = LEN_W'(l);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_SYMBOLS; i++) begin
			match[i] = valid_q[i] && (len_q[i] == acc_len_nx)
				&& (CMP_W'(bits_q[i]) == acc_bits_nx);
		end
	end

endmodule

@@ hdl/pcbd_prio.sv @@
// lowest-index-first priority encoder as a binary tree over the match vector
// depends on pcbd_pkg
module pcbd_prio (
	input  logic [pcbd_pkg::NUM_SYMBOLS-1:0] match,
	output logic                             hit,
	output logic [pcbd_pkg::SYM_W-1:0]       idx
);
	import pcbd_pkg::*;

	localparam int P = 1 << SYM_W;

	logic             h_l [SYM_W+1][P];
	logic [SYM_W-1:0] i_l [SYM_W+1][P];

	always_comb begin
		for (int k = 0; k <= SYM_W; k++) begin
			for (int j = 0; j < P; j++) begin
				h_l[k][j] = 1'b0;
				i_l[k][j] = '0;
			end
		end
		for (int j = 0; j < NUM_SYMBOLS; j++) begin
			h_l[0][j] = match[j];
			i_l[0][j] = SYM_W'(j);
		end
		for (int k = 0; k < SYM_W; k++) begin
			for (int j = 0; j < (P >> (k + 1)); j++) begin
				h_l[k+1][j] = h_l[k][2*j] || h_l[k][2*j+1];
				i_l[k+1][j] = h_l[k][2*j] ? i_l[k][2*j] : i_l[k][2*j+1];
			end
		end
	end

	assign hit = h_l[SYM_W][0];
	assign idx = i_l[SYM_W][0];

endmodule

@@ bench/prefix_code_bit_decoder_test.sv @@
`timescale 1ns / 1ps
// self-checking bench for prefix_code_bit_decoder: directed words, then random code tables
// with encoded streams; a tracker class predicts every decoded symbol and checks done words
// depends on pcbd_pkg and prefix_code_bit_decoder

class decode_tracker;
	typedef struct {
		logic                        kind;
		logic [pcbd_pkg::SYMP_W-1:0] sym;
	} outcome_t;

	bit                          tbl_valid [pcbd_pkg::NUM_SYMBOLS];
	bit [pcbd_pkg::CODE_W-1:0]   tbl_code  [pcbd_pkg::NUM_SYMBOLS];
	bit [pcbd_pkg::LEN_W-1:0]    tbl_len   [pcbd_pkg::NUM_SYMBOLS];
	bit [pcbd_pkg::ACC_W-1:0]    shift_bits;
	int                          shift_len;
	outcome_t                    awaited [$];
	int                          faults;

	function new();
		faults = 0;
		forget_all();
	endfunction

	function void forget_all();
		foreach (tbl_valid[i]) begin
			tbl_valid[i] = 1'b0;
			tbl_code[i]  = '0;
			tbl_len[i]   = '0;
		end
		shift_bits = '0;
		shift_len  = 0;
	endfunction

	function void note_word(logic [pcbd_pkg::CMD_W-1:0] c, logic [pcbd_pkg::SYMP_W-1:0] s,
			logic [pcbd_pkg::CODE_W-1:0] code, logic [pcbd_pkg::LEN_W-1:0] len, logic b);
		int       longest;
		bit       hit;
		outcome_t o;
		longest = 0;
		hit = 1'b0;
		if (c == pcbd_pkg::CMD_CLEAR) begin
			forget_all();
		end else if (c == pcbd_pkg::CMD_LOAD) begin
			tbl_len[s]   = len;
			tbl_code[s]  = code & ~({pcbd_pkg::CODE_W{1'b1}} << len);
			tbl_valid[s] = (len >= 1) && (len <= pcbd_pkg::MAX_CODE_LEN);
		end else if (c == pcbd_pkg::CMD_DECODE) begin
			shift_bits = {shift_bits[pcbd_pkg::ACC_W-2:0], b};
			shift_len++;
			foreach (tbl_valid[i])
				if (tbl_valid[i] && int'(tbl_len[i]) > longest)
					longest = int'(tbl_len[i]);
			foreach (tbl_valid[i]) begin
				if (!hit && tbl_valid[i] && int'(tbl_len[i]) == shift_len
						&& tbl_code[i] == shift_bits) begin
					hit    = 1'b1;
					o.kind = pcbd_pkg::KIND_SYMBOL;
					o.sym  = i[pcbd_pkg::SYMP_W-1:0];
				end
			end
			if (!hit && shift_len >= longest) begin
				hit    = 1'b1;
				o.kind = pcbd_pkg::KIND_OVERFLOW;
				o.sym  = '0;
			end
			if (hit) begin
				awaited.insert(awaited.size(), o);
				shift_bits = '0;
				shift_len  = 0;
			end
		end
	endfunction

	function void check_symbol(logic kind, logic [pcbd_pkg::SYMP_W-1:0] sym);
		outcome_t o;
		if (awaited.size() == 0) begin
			$error("unexpected word: result_kind %0d decoded_symbol %0d", kind, sym);
			faults++;
		end else begin
			o = awaited.pop_front();
			if (kind !== o.kind) begin
				$error("result_kind: expected %0d, actual %0d", o.kind, kind);
				faults++;
			end
			if (sym !== o.sym) begin
				$error("decoded_symbol: expected %0d, actual %0d", o.sym, sym);
				faults++;
			end
		end
	endfunction
endclass

module prefix_code_bit_decoder_test;
	import pcbd_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 8;
	localparam int WORD_TARGET  = 1350;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [CMD_W-1:0]   cmd;
	logic [SYMP_W-1:0]  entry_symbol;
	logic [CODE_W-1:0]  entry_code;
	logic [LEN_W-1:0]   entry_length;
	logic               data_bit;
	logic               done;
	logic               result_kind;
	logic [SYMP_W-1:0]  decoded_symbol;

	decode_tracker tracker;
	int            words_sent = 0;
	int            idle_cycles = 0;
	bit            calm = 1'b0;

	prefix_code_bit_decoder dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.entry_symbol   (entry_symbol),
		.entry_code     (entry_code),
		.entry_length   (entry_length),
		.data_bit       (data_bit),
		.done           (done),
		.result_kind    (result_kind),
		.decoded_symbol (decoded_symbol)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				tracker.note_word(cmd, entry_symbol, entry_code, entry_length, data_bit);
			if (done)
				tracker.check_symbol(result_kind, decoded_symbol);
		end
	end

	always @(posedge clk) begin
		if ((arst_n && start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_word(logic [CMD_W-1:0] c, logic [SYMP_W-1:0] s, logic [CODE_W-1:0] code,
			logic [LEN_W-1:0] len, logic b);
		if (!calm && $urandom_range(99) < 10) begin
			start        <= 1'b0;
			cmd          <= CMD_W'($urandom);
			entry_symbol <= SYMP_W'($urandom);
			entry_code   <= CODE_W'($urandom);
			entry_length <= LEN_W'($urandom);
			data_bit     <= 1'($urandom);
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start        <= 1'b1;
		cmd          <= c;
		entry_symbol <= s;
		entry_code   <= code;
		entry_length <= len;
		data_bit     <= b;
		do @(posedge clk); while (busy);
		if (c != CMD_UNUSED)
			words_sent++;
	endtask

	task automatic load_entry(logic [SYMP_W-1:0] s, logic [CODE_W-1:0] code, logic [LEN_W-1:0] len);
		send_word(CMD_LOAD, s, code, len, 1'($urandom));
	endtask

	task automatic decode_bit(logic b);
		send_word(CMD_DECODE, SYMP_W'($urandom), CODE_W'($urandom), LEN_W'($urandom), b);
	endtask

	task automatic clear_table();
		send_word(CMD_CLEAR, SYMP_W'($urandom), CODE_W'($urandom), LEN_W'($urandom),
			1'($urandom));
	endtask

	// random prefix-free table from leaf splitting, then a stream of its codes with stray bits and unused words
	task automatic run_phase();
		bit [CODE_W-1:0] leaf_code [NUM_SYMBOLS];
		int              leaf_len  [NUM_SYMBOLS];
		bit              sym_taken [NUM_SYMBOLS];
		bit [CODE_W-1:0] garbage;
		int              depth_cap, target, leaves, pick, k, j, n, bitpos, extra;
		foreach (sym_taken[i])
			sym_taken[i] = 1'b0;
		if ($urandom_range(3) != 0)
			clear_table();
		depth_cap = $urandom_range(2, MAX_CODE_LEN);
		target = ($urandom_range(9) == 0) ? $urandom_range(30, 120) : $urandom_range(2, 12);
		if (depth_cap < 8 && target > (1 << depth_cap))
			target = 1 << depth_cap;
		leaf_code[0] = '0;
		leaf_len[0]  = 0;
		leaves = 1;
		while (leaves < target) begin
			pick = $urandom_range(leaves - 1);
			if (leaf_len[pick] >= depth_cap || $urandom_range(2) == 0) begin
				extra = -1;
				for (j = 0; j < leaves; j++)
					if (leaf_len[j] < depth_cap && (extra < 0 || leaf_len[j] > leaf_len[extra]))
						extra = j;
				pick = extra;
			end
			leaf_code[leaves] = {leaf_code[pick][CODE_W-2:0], 1'b1};
			leaf_len[leaves]  = leaf_len[pick] + 1;
			leaf_code[pick]   = {leaf_code[pick][CODE_W-2:0], 1'b0};
			leaf_len[pick]++;
			leaves++;
		end
		for (j = 0; j < leaves; j++) begin
			if ($urandom_range(7) != 0) begin
				do k = $urandom_range(NUM_SYMBOLS - 1); while (sym_taken[k]);
				sym_taken[k] = 1'b1;
				garbage = '0;
				if ($urandom_range(1) == 0)
					garbage = CODE_W'($urandom) & ({CODE_W{1'b1}} << leaf_len[j]);
				load_entry(SYMP_W'(k), leaf_code[j] | garbage, LEN_W'(leaf_len[j]));
			end
			if ($urandom_range(15) == 0) begin
				do k = $urandom_range(NUM_SYMBOLS - 1); while (sym_taken[k]);
				sym_taken[k] = 1'b1;
				if ($urandom_range(2) == 0)
					load_entry(SYMP_W'(k), leaf_code[j], LEN_W'(leaf_len[j]));
				else if ($urandom_range(1) == 0)
					load_entry(SYMP_W'(k), CODE_W'($urandom), '0);
				else
					load_entry(SYMP_W'(k), CODE_W'($urandom),
						LEN_W'($urandom_range(MAX_CODE_LEN + 1, 31)));
			end
		end
		n = $urandom_range(10, 40);
		for (j = 0; j < n; j++) begin
			k = $urandom_range(39);
			if (k < 3) begin
				repeat ($urandom_range(1, 3)) decode_bit(1'($urandom));
			end else if (k == 3) begin
				send_word(CMD_UNUSED, SYMP_W'($urandom), CODE_W'($urandom), LEN_W'($urandom),
					1'($urandom));
			end else begin
				pick = $urandom_range(leaves - 1);
				for (bitpos = leaf_len[pick] - 1; bitpos >= 0; bitpos--)
					decode_bit(leaf_code[pick][bitpos]);
			end
		end
	endtask

	initial begin
		int phase;
		tracker      = new();
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = CMD_CLEAR;
		entry_symbol = '0;
		entry_code   = '0;
		entry_length = '0;
		data_bit     = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// empty table after reset
		decode_bit(1'b1);
		send_word(CMD_UNUSED, 8'hFF, 16'hFFFF, 5'h1F, 1'b1);
		// code wider than length, duplicate codes, unusable lengths
		load_entry(8'd0, 16'hFFFE, 5'd1);
		load_entry(8'd5, 16'h0003, 5'd2);
		load_entry(8'd3, 16'hFFFF, 5'd2);
		load_entry(8'd255, 16'hFFFF, 5'd16);
		load_entry(8'd1, 16'h0005, 5'd0);
		load_entry(8'd2, 16'h0000, 5'd17);
		load_entry(8'd4, 16'h7FFF, 5'd31);
		decode_bit(1'b0);
		decode_bit(1'b1);
		decode_bit(1'b1);
		decode_bit(1'b1);
		decode_bit(1'b0);
		// clear drops the partial code
		clear_table();
		decode_bit(1'b0);
		load_entry(8'd7, 16'h0001, 5'd1);
		decode_bit(1'b0);
		decode_bit(1'b1);
		load_entry(8'd7, 16'h0001, 5'd0);
		decode_bit(1'b1);

		phase = 0;
		while (words_sent < WORD_TARGET) begin
			calm = (phase == 3 || phase == 4);
			run_phase();
			phase++;
		end
		start <= 1'b0;

		while (tracker.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.faults == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
